>>> design/vmt_pkg.sv
// Shared types, request codes and defaults for the vector/matrix transform core.
// No dependencies; used by vmt_lane and vector_matrix_transform_core.
package vmt_pkg;

    localparam int DATA_W            = 32;
    localparam int LANES             = 4;
    localparam int COEFFS            = LANES * LANES;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_VEC4  = 2'd1;
    localparam logic [1:0] REQ_POINT = 2'd2;

    localparam logic [LANES-1:0] MASK_NONE  = 4'b0000;
    localparam logic [LANES-1:0] MASK_POINT = 4'b0111;
    localparam logic [LANES-1:0] MASK_VEC4  = 4'b1111;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef data_t vec4_t [LANES];

    localparam data_t DATA_MAX = 32'sh7FFF_FFFF;
    localparam data_t DATA_MIN = 32'sh8000_0000;

endpackage

>>> design/vmt_lane.sv
// One output column: four Q-format products registered, then summed and clamped.
// Depends on vmt_pkg.
module vmt_lane #(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           capture,
    input  vmt_pkg::vec4_t vec,
    input  vmt_pkg::vec4_t coef,
    output vmt_pkg::data_t result,
    output logic           saturated
);

    localparam int PROD_W = 2 * vmt_pkg::DATA_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(vmt_pkg::DATA_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(vmt_pkg::DATA_MIN);

    logic signed [PROD_W-1:0] prod      [vmt_pkg::LANES];
    logic signed [TERM_W-1:0] term_next [vmt_pkg::LANES];
    logic signed [TERM_W-1:0] term_reg  [vmt_pkg::LANES];
    logic signed [SUM_W-1:0]  sum;
    logic                     over_hi;
    logic                     over_lo;

    // floor shift: drop fraction bits of the full product
    always_comb
    begin
        for (int i = 0; i < vmt_pkg::LANES; i++)
        begin
            prod[i]      = PROD_W'(vec[i]) * PROD_W'(coef[i]);
            term_next[i] = prod[i][PROD_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < vmt_pkg::LANES; i++)
            begin
                term_reg[i] <= term_next[i];
            end
        end
    end

    always_comb
    begin
        sum = SUM_W'(term_reg[0]) + SUM_W'(term_reg[1])
            + SUM_W'(term_reg[2]) + SUM_W'(term_reg[3]);
        over_hi = (sum > SUM_MAX);
        over_lo = (sum < SUM_MIN);
        if (over_hi)
        begin
            result = vmt_pkg::DATA_MAX;
        end
        else if (over_lo)
        begin
            result = vmt_pkg::DATA_MIN;
        end
        else
        begin
            result = sum[vmt_pkg::DATA_W-1:0];
        end
        saturated = over_hi | over_lo;
    end

endmodule

>>> design/vector_matrix_transform_core.sv
// Pipeline: product stage, then merge/output register; one transaction per cycle
// unless out_ready stalls the pipeline; a load updates the matrix in time for the
// transform accepted on the next cycle. Four column lanes each hold four multipliers.
// Reset (rst_n, async, active low) clears the matrix to zero and empties the pipeline.
// Top level: coefficient registers, four vmt_lane instances, merge/output register.
// Depends on vmt_pkg and vmt_lane.
module vector_matrix_transform_core #(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    input  logic [1:0]     row_index,
    input  logic [1:0]     col_index,
    input  vmt_pkg::data_t in_x,
    input  vmt_pkg::data_t in_y,
    input  vmt_pkg::data_t in_z,
    input  vmt_pkg::data_t in_w,
    output logic           out_valid,
    input  logic           out_ready,
    output vmt_pkg::data_t out_x,
    output vmt_pkg::data_t out_y,
    output vmt_pkg::data_t out_z,
    output vmt_pkg::data_t out_w,
    output logic           saturated
);

    localparam vmt_pkg::data_t ONE_Q = vmt_pkg::DATA_W'(64'sd1 <<< FRAC_BITS);

    vmt_pkg::data_t                coeff_reg [vmt_pkg::COEFFS];
    vmt_pkg::vec4_t                vec;
    vmt_pkg::vec4_t                lane_coef [vmt_pkg::LANES];
    vmt_pkg::data_t                lane_result [vmt_pkg::LANES];
    logic [vmt_pkg::LANES-1:0]     lane_sat;

    logic                          accept;
    logic                          s1_ready;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [vmt_pkg::LANES-1:0]     s1_mask_reg;
    logic [vmt_pkg::LANES-1:0]     s1_mask_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    vmt_pkg::data_t                out_x_reg;
    vmt_pkg::data_t                out_y_reg;
    vmt_pkg::data_t                out_z_reg;
    vmt_pkg::data_t                out_w_reg;
    logic                          sat_reg;
    vmt_pkg::data_t                merged [vmt_pkg::LANES];

    assign s1_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // coefficient store, index row*4+col
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < vmt_pkg::COEFFS; k++)
            begin
                coeff_reg[k] <= '0;
            end
        end
        else if (accept && (req_type == vmt_pkg::REQ_LOAD))
        begin
            coeff_reg[{row_index, col_index}] <= in_x;
        end
    end

    // point mode feeds 1.0 as w
    always_comb
    begin
        vec[0] = in_x;
        vec[1] = in_y;
        vec[2] = in_z;
        vec[3] = (req_type == vmt_pkg::REQ_POINT) ? ONE_Q : in_w;
    end

    always_comb
    begin
        case (req_type)
            vmt_pkg::REQ_VEC4:  s1_mask_next = vmt_pkg::MASK_VEC4;
            vmt_pkg::REQ_POINT: s1_mask_next = vmt_pkg::MASK_POINT;
            default:            s1_mask_next = vmt_pkg::MASK_NONE;
        endcase
    end

    genvar j, i;
    generate
        for (j = 0; j < vmt_pkg::LANES; j++)
        begin : g_lane
            for (i = 0; i < vmt_pkg::LANES; i++)
            begin : g_col
                assign lane_coef[j][i] = coeff_reg[i * vmt_pkg::LANES + j];
            end

            vmt_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .clk       (clk),
                .capture   (accept),
                .vec       (vec),
                .coef      (lane_coef[j]),
                .result    (lane_result[j]),
                .saturated (lane_sat[j])
            );
        end
    endgenerate

    always_comb
    begin
        s1_valid_next = in_ready ? in_valid : s1_valid_reg;
        out_valid_next = s1_ready ? s1_valid_reg : out_valid_reg;
        for (int k = 0; k < vmt_pkg::LANES; k++)
        begin
            merged[k] = s1_mask_reg[k] ? lane_result[k] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_mask_reg   <= vmt_pkg::MASK_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                s1_mask_reg <= s1_mask_next;
            end
        end
    end

    // merge stage: mask inactive lanes, OR the clamp flags
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_ready)
        begin
            out_x_reg <= merged[0];
            out_y_reg <= merged[1];
            out_z_reg <= merged[2];
            out_w_reg <= merged[3];
            sat_reg   <= |(lane_sat & s1_mask_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_w     = out_w_reg;
    assign saturated = sat_reg;

    a_mask_legal: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_mask_reg == vmt_pkg::MASK_NONE)
                      || (s1_mask_reg == vmt_pkg::MASK_POINT)
                      || (s1_mask_reg == vmt_pkg::MASK_VEC4))
        else $error("lane mask holds an illegal pattern");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> (s1_valid_reg && $stable(s1_mask_reg)))
        else $error("stalled product stage lost its transaction");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (out_x == vmt_pkg::DATA_MAX) || (out_x == vmt_pkg::DATA_MIN)
         || (out_y == vmt_pkg::DATA_MAX) || (out_y == vmt_pkg::DATA_MIN)
         || (out_z == vmt_pkg::DATA_MAX) || (out_z == vmt_pkg::DATA_MIN)
         || (out_w == vmt_pkg::DATA_MAX) || (out_w == vmt_pkg::DATA_MIN))
        else $error("saturated set with no clamped component");

endmodule

>>> tb/vector_matrix_transform_core_test.sv
// Self-checking testbench for vector_matrix_transform_core: matrix loads, vec4 and point
// transforms with saturation, driven and predicted in Q16.16 under random handshake idling.
// Depends on vmt_pkg and the design files of vector_matrix_transform_core.
module vector_matrix_transform_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_REQS = 634;

    typedef struct {
        logic [1:0]     kind;
        logic [1:0]     row;
        logic [1:0]     col;
        vmt_pkg::data_t x;
        vmt_pkg::data_t y;
        vmt_pkg::data_t z;
        vmt_pkg::data_t w;
        bit             drain;
    } vertex_req_t;

    typedef struct {
        vmt_pkg::data_t x;
        vmt_pkg::data_t y;
        vmt_pkg::data_t z;
        vmt_pkg::data_t w;
        logic           sat;
    } vertex_res_t;

    typedef enum int {READY_ALWAYS, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    logic [1:0]     req_type  = vmt_pkg::REQ_LOAD;
    logic [1:0]     row_index = 2'd0;
    logic [1:0]     col_index = 2'd0;
    vmt_pkg::data_t in_x      = '0;
    vmt_pkg::data_t in_y      = '0;
    vmt_pkg::data_t in_z      = '0;
    vmt_pkg::data_t in_w      = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    vmt_pkg::data_t out_x;
    vmt_pkg::data_t out_y;
    vmt_pkg::data_t out_z;
    vmt_pkg::data_t out_w;
    logic           saturated;

    vertex_req_t    vertex_reqs[$];
    vertex_res_t    expected_vertices[$];
    vmt_pkg::data_t matrix_model [vmt_pkg::COEFFS];
    vertex_req_t    in_flight;
    int             fail_count  = 0;
    int             cycle_count = 0;
    int             burst_left  = 0;
    int             gap_left    = 0;
    stall_mode_t    stall_mode  = READY_ALWAYS;
    int             mode_left   = 0;
    int             stall_period = 2;
    int             stall_phase = 0;

    vector_matrix_transform_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .row_index (row_index),
        .col_index (col_index),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_w      (in_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .saturated (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Row vector times matrix; products floored to Q16.16, sums clamped.
    function automatic vertex_res_t transform_vertex(input vertex_req_t req);
        vertex_res_t        res;
        logic signed [63:0] comp [vmt_pkg::LANES];
        logic signed [63:0] vin [vmt_pkg::LANES];
        logic signed [63:0] coeff;
        logic signed [63:0] acc;
        vmt_pkg::data_t     lane_out [vmt_pkg::LANES];
        res = '{x: '0, y: '0, z: '0, w: '0, sat: 1'b0};
        if (req.kind == vmt_pkg::REQ_LOAD)
        begin
            matrix_model[{req.row, req.col}] = req.x;
            return res;
        end
        if (req.kind != vmt_pkg::REQ_VEC4 && req.kind != vmt_pkg::REQ_POINT)
            return res;
        vin[0] = 64'(req.x);
        vin[1] = 64'(req.y);
        vin[2] = 64'(req.z);
        vin[3] = 64'(req.w);
        for (int j = 0; j < vmt_pkg::LANES; j++)
        begin
            lane_out[j] = '0;
            if (req.kind == vmt_pkg::REQ_POINT && j == 3)
                continue;
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                coeff = 64'(matrix_model[i * vmt_pkg::LANES + j]);
                acc += (vin[i] * coeff) >>> vmt_pkg::FRAC_BITS_DEFAULT;
            end
            coeff = 64'(matrix_model[12 + j]);
            if (req.kind == vmt_pkg::REQ_VEC4)
                acc += (vin[3] * coeff) >>> vmt_pkg::FRAC_BITS_DEFAULT;
            else
                acc += coeff;
            if (acc > 64'sh7FFF_FFFF)
            begin
                lane_out[j] = vmt_pkg::DATA_MAX;
                res.sat = 1'b1;
            end
            else if (acc < -64'sh8000_0000)
            begin
                lane_out[j] = vmt_pkg::DATA_MIN;
                res.sat = 1'b1;
            end
            else
                lane_out[j] = vmt_pkg::data_t'(acc[31:0]);
        end
        res.x = lane_out[0];
        res.y = lane_out[1];
        res.z = lane_out[2];
        res.w = lane_out[3];
        return res;
    endfunction

    function automatic vmt_pkg::data_t random_fixed();
        logic [31:0] raw;
        case ($urandom_range(0, 15))
            0: return vmt_pkg::DATA_MAX;
            1: return vmt_pkg::DATA_MIN;
            2: return '0;
            3, 4, 5: return vmt_pkg::data_t'($urandom());
            default:
            begin
                raw = $urandom_range(0, 32'h001F_FFFF);
                return vmt_pkg::data_t'(raw - 32'h0010_0000);
            end
        endcase
    endfunction

    function automatic void queue_req(input logic [1:0] kind, input logic [1:0] row,
                                      input logic [1:0] col, input vmt_pkg::data_t x,
                                      input vmt_pkg::data_t y, input vmt_pkg::data_t z,
                                      input vmt_pkg::data_t w);
        vertex_reqs.push_back('{kind: kind, row: row, col: col, x: x, y: y, z: z, w: w,
                                drain: 1'b0});
    endfunction

    function automatic void queue_drain();
        vertex_reqs.push_back('{kind: vmt_pkg::REQ_LOAD, row: 2'd0, col: 2'd0, x: '0, y: '0,
                                z: '0, w: '0, drain: 1'b1});
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sender: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int k = 0; k < vmt_pkg::COEFFS; k++)
                matrix_model[k] = '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_vertices.push_back(transform_vertex(in_flight));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (vertex_reqs.size() == 0)
                    in_valid <= 1'b0;
                else if (vertex_reqs[0].drain)
                begin
                    in_valid <= 1'b0;
                    if (expected_vertices.size() == 0)
                        void'(vertex_reqs.pop_front());
                end
                else
                begin
                    in_flight = vertex_reqs.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= in_flight.kind;
                    row_index <= in_flight.row;
                    col_index <= in_flight.col;
                    in_x      <= in_flight.x;
                    in_y      <= in_flight.y;
                    in_z      <= in_flight.z;
                    in_w      <= in_flight.w;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        burst_left = $urandom_range(60, 200);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: checks each result and picks a new random stall mode when its mode counter runs out.
    always @(posedge clk or negedge rst_n)
    begin
        vertex_res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $error("result transaction with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    compare_field("out_x", want.x, out_x);
                    compare_field("out_y", want.y, out_y);
                    compare_field("out_z", want.z, out_z);
                    compare_field("out_w", want.w, out_w);
                    compare_field("saturated", {31'd0, want.sat}, {31'd0, saturated});
                end
            end
            if (mode_left == 0)
            begin
                stall_mode   = stall_mode_t'($urandom_range(0, 3));
                mode_left    = $urandom_range(32, 200);
                stall_period = $urandom_range(2, 5);
            end
            else
                mode_left--;
            stall_phase++;
            case (stall_mode)
                READY_ALWAYS:   out_ready <= 1'b1;
                STALL_SPARSE:   out_ready <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: out_ready <= (stall_phase % stall_period == 0);
                default:        out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int sel;
        // zero matrix after reset, unused request code
        queue_req(vmt_pkg::REQ_VEC4, 2'd3, 2'd3, vmt_pkg::DATA_MAX, vmt_pkg::DATA_MIN,
                  vmt_pkg::DATA_MAX, vmt_pkg::DATA_MIN);
        queue_req(REQ_UNUSED, 2'd2, 2'd1, vmt_pkg::DATA_MAX, vmt_pkg::DATA_MAX,
                  vmt_pkg::DATA_MIN, 32'sh1234_5678);
        queue_req(vmt_pkg::REQ_LOAD, 2'd0, 2'd0, vmt_pkg::DATA_MIN, '0, '0, '0);
        queue_req(vmt_pkg::REQ_LOAD, 2'd1, 2'd1, vmt_pkg::DATA_MAX, '0, '0, '0);
        queue_req(vmt_pkg::REQ_LOAD, 2'd2, 2'd2, 32'sh0001_0000, '0, '0, '0);
        queue_req(vmt_pkg::REQ_LOAD, 2'd3, 2'd3, -32'sh0001_0000, '0, '0, '0);
        queue_req(vmt_pkg::REQ_LOAD, 2'd3, 2'd0, vmt_pkg::DATA_MAX, '0, '0, '0);
        queue_req(vmt_pkg::REQ_LOAD, 2'd3, 2'd1, vmt_pkg::DATA_MIN, '0, '0, '0);
        // positive overflow on x, extremes elsewhere
        queue_req(vmt_pkg::REQ_VEC4, 2'd0, 2'd0, vmt_pkg::DATA_MIN, vmt_pkg::DATA_MAX,
                  -32'sd1, 32'sd1);
        queue_req(vmt_pkg::REQ_POINT, 2'd1, 2'd2, vmt_pkg::DATA_MIN, vmt_pkg::DATA_MIN,
                  vmt_pkg::DATA_MAX, vmt_pkg::DATA_MAX);
        // floor rounding of tiny negative products
        queue_req(vmt_pkg::REQ_LOAD, 2'd0, 2'd0, 32'sd1, '0, '0, '0);
        queue_req(vmt_pkg::REQ_VEC4, 2'd0, 2'd0, -32'sd1, 32'sd1, -32'sd3, -32'sh0000_8000);
        // negative overflow
        queue_req(vmt_pkg::REQ_LOAD, 2'd0, 2'd1, vmt_pkg::DATA_MAX, '0, '0, '0);
        queue_req(vmt_pkg::REQ_VEC4, 2'd2, 2'd3, vmt_pkg::DATA_MIN, '0, '0, '0);
        // point mode ignores in_w
        queue_req(vmt_pkg::REQ_POINT, 2'd3, 2'd0, 32'sh0002_0000, -32'sh0001_8000, 32'sd7,
                  vmt_pkg::DATA_MIN);
        queue_req(vmt_pkg::REQ_VEC4, 2'd1, 2'd1, '0, '0, '0, '0);
        queue_drain();
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 160 == 80)
                queue_drain();
            sel = $urandom_range(0, 99);
            queue_req((sel < 25) ? vmt_pkg::REQ_LOAD : (sel < 60) ? vmt_pkg::REQ_VEC4 :
                      (sel < 95) ? vmt_pkg::REQ_POINT : REQ_UNUSED,
                      2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      random_fixed(), random_fixed(), random_fixed(), random_fixed());
        end
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        while (vertex_reqs.size() > 0 || in_valid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_vertices.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
